// File: hdl/pfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared constants, types and the coefficient table builder for the PCM
// FIR decimator.
// ----------------------------------------------------------------------------
package pfd_pkg;

   localparam int MAX_TAPS      = 511;
   localparam int COEF_BITS     = 18;
   localparam int COEF_FRAC     = 17;
   localparam int FACTOR_BITS   = 5;
   localparam int PHASE_BITS    = 4;
   localparam int FACTOR_FILTER = 2;
   localparam int FACTOR_MAX    = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int FACTOR_RESET  = 2;

   // word select inside the register window (paddr[2])
   localparam logic REG_DECIMATION_FACTOR = 1'b0;

   localparam longint FC_HZ     = 64'sd78000;
   localparam longint FS_HZ     = 64'sd352800;
   localparam longint WIN_A0    = 64'sd35875;
   localparam longint WIN_A1    = 64'sd48829;
   localparam longint WIN_A2    = 64'sd14128;
   localparam longint WIN_A3    = 64'sd1168;
   localparam longint WIN_DEN   = 64'sd100000;
   localparam longint Q30_ONE   = 64'sd1073741824;
   localparam longint PI_Q30    = 64'sd3373259426;
   localparam longint COEF_MAX  = 64'sd131071;
   localparam longint COEF_MIN  = -64'sd131072;
   localparam int     SIN_TERMS = 7;

   typedef logic [MAX_TAPS-1:0][COEF_BITS-1:0] coef_table_type;

   // quotient of non-negative num by positive den, restoring long division
   function automatic longint div_pos(input longint num, input longint den);
      longint quo;
      longint rem;
      quo = 64'sd0;
      rem = 64'sd0;
      for (int b = 62; b >= 0; b--) begin
         rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | (64'sd1 <<< b);
         end
      end
      return quo;
   endfunction

   // rounds half away from zero
   function automatic longint div_round(input longint num, input longint den);
      if (den <= 64'sd0) begin
         return 64'sd0;
      end
      if (num >= 64'sd0) begin
         return div_pos(num + (den >>> 1), den);
      end
      return -div_pos(-num + (den >>> 1), den);
   endfunction

   function automatic longint mul_q30(input longint a, input longint b);
      return (a * b + (Q30_ONE >>> 1)) >>> 30;
   endfunction

   // sin(pi * p / q) in Q30, p >= 0, q > 0
   function automatic longint sin_pi_frac(input longint p, input longint q);
      longint two_q;
      longint r;
      longint a;
      longint a2;
      longint term;
      longint sum;
      logic   neg;
      two_q = q <<< 1;
      r     = p - two_q * div_pos(p, two_q);
      neg   = 1'b0;
      if (r >= q) begin
         r   = r - q;
         neg = 1'b1;
      end
      if ((r <<< 1) > q) begin
         r = q - r;
      end
      a    = div_pos(PI_Q30 * r + (q >>> 1), q);
      a2   = mul_q30(a, a);
      term = a;
      sum  = a;
      for (int n = 1; n <= SIN_TERMS; n++) begin
         term = div_pos(mul_q30(term, a2), longint'((2 * n) * (2 * n + 1)));
         if ((n & 1) != 0) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return neg ? -sum : sum;
   endfunction

   // Blackman-Harris windowed sinc, unity DC gain, Q1.17
   function automatic coef_table_type build_coef_rom(input int taps);
      coef_table_type rom;
      longint         h [MAX_TAPS];
      longint         den;
      longint         total;
      longint         c1;
      longint         c2;
      longint         c3;
      longint         w;
      longint         x2;
      longint         ax2;
      longint         sinc;
      longint         s;
      longint         theta;
      longint         c;
      rom   = '0;
      den   = longint'(taps - 1);
      total = 64'sd0;
      for (int i = 0; i < taps; i++) begin
         c1 = sin_pi_frac(64'sd4 * longint'(i) + den, 64'sd2 * den);
         c2 = sin_pi_frac(64'sd8 * longint'(i) + den, 64'sd2 * den);
         c3 = sin_pi_frac(64'sd12 * longint'(i) + den, 64'sd2 * den);
         w  = div_round(WIN_A0 * Q30_ONE - WIN_A1 * c1 + WIN_A2 * c2 - WIN_A3 * c3,
                        WIN_DEN);
         x2  = 64'sd2 * longint'(i) - den;
         ax2 = (x2 < 64'sd0) ? -x2 : x2;
         if (ax2 == 64'sd0) begin
            sinc = Q30_ONE;
         end else begin
            s     = sin_pi_frac(FC_HZ * ax2, FS_HZ);
            theta = div_round(PI_Q30 * FC_HZ * ax2, FS_HZ);
            sinc  = div_round(s * Q30_ONE, theta);
         end
         h[i]  = div_round(sinc * w, Q30_ONE);
         total = total + h[i];
      end
      if (total <= 64'sd0) begin
         total = 64'sd1;
      end
      for (int i = 0; i < taps; i++) begin
         c = div_round(h[i] * (64'sd1 <<< COEF_FRAC), total);
         if (c > COEF_MAX) begin
            c = COEF_MAX;
         end
         if (c < COEF_MIN) begin
            c = COEF_MIN;
         end
         rom[i] = c[COEF_BITS-1:0];
      end
      return rom;
   endfunction

endpackage
`default_nettype wire

// File: hdl/pcm_fir_decimator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_fir_decimator_core
// Per-channel PCM decimator: pass-through, windowed-sinc FIR halving, or
// keep-every-n-th, chosen by the decimation_factor register.
//
// req_ beats carry one sample and its channel; rsp_ beats carry one result.
// A beat moves when valid is high and stall is low. csr_ is an APB-style
// port; decimation_factor sits at byte address 0 and resets to 2.
// A halving (filtered) beat holds req_stall high while one shared
// multiply-accumulate walks one tap per cycle through the history RAM,
// then while the pipeline drains and the beat commits. Any other beat goes
// straight from idle to the commit step.
// The result appears in the output register right after the commit cycle.
// Reset zeroes phases and fill counts; history entries not yet written read
// as zero through the fill count, so no clearing pass is needed.
// While rsp_stall holds a result, the next req_ beat is still taken; only a
// second result waits in the commit step until the register frees up.
// ----------------------------------------------------------------------------
module pcm_fir_decimator_core #(
   parameter int TAPS        = 255,
   parameter int CHANNELS    = 2,
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // input channel
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0]          req_in_sample,
   input  wire logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] req_in_channel,
   // result channel
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]               rsp_out_sample,
   output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rsp_out_channel,
   // register port
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [pfd_pkg::CSR_ADDR_BITS-1:0]      csr_paddr,
   input  wire logic [pfd_pkg::CSR_DATA_BITS-1:0]      csr_pwdata,
   output logic [pfd_pkg::CSR_DATA_BITS-1:0]           csr_prdata,
   output logic                                        csr_pready
);

   localparam int HIST_LEN      = TAPS - 1;
   localparam int TAP_BITS      = $clog2(TAPS);
   localparam int HIST_IDX_BITS = $clog2(HIST_LEN);
   localparam int CH_BITS       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int MEM_DEPTH     = CHANNELS * HIST_LEN;
   localparam int MEM_AW        = $clog2(MEM_DEPTH);
   localparam int ROM_IDX_BITS  = $clog2(pfd_pkg::MAX_TAPS);
   localparam int PROD_BITS     = pfd_pkg::COEF_BITS + SAMPLE_BITS;
   localparam int ACC_BITS      = PROD_BITS + TAP_BITS;
   localparam int ROUND_HALF    = 1 << (pfd_pkg::COEF_FRAC - 1);

   localparam pfd_pkg::coef_table_type COEF_ROM = pfd_pkg::build_coef_rom(TAPS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   // control
   state_type                            state_ff;
   logic [pfd_pkg::FACTOR_BITS-1:0]      factor_ff;
   logic [pfd_pkg::PHASE_BITS-1:0]       phase_ff [CHANNELS];
   logic [HIST_IDX_BITS-1:0]             wp_ff    [CHANNELS];
   logic [TAP_BITS-1:0]                  fill_ff  [CHANNELS];
   logic                                 s1_act_ff;
   logic                                 s2_act_ff;
   logic                                 rsp_valid_ff;

   // current beat
   logic signed [SAMPLE_BITS-1:0]        x_ff;
   logic [CH_BITS-1:0]                   ch_ff;
   logic                                 emit_ff;
   logic                                 filt_ff;
   logic [MEM_AW-1:0]                    base_ff;
   logic [HIST_IDX_BITS-1:0]             rp_ff;
   logic [TAP_BITS-1:0]                  start_ff;
   logic [TAP_BITS-1:0]                  tap_ff;

   // MAC pipeline
   logic                                 s1_use_x_ff;
   logic                                 s1_live_ff;
   logic signed [pfd_pkg::COEF_BITS-1:0] coef1_ff;
   logic signed [SAMPLE_BITS-1:0]        mem_rd_ff;
   logic signed [PROD_BITS-1:0]          prod_ff;
   logic signed [ACC_BITS-1:0]           acc_ff;

   // output register
   logic signed [SAMPLE_BITS-1:0]        rsp_sample_ff;
   logic [CH_BITS-1:0]                   rsp_channel_ff;

   // history RAM
   logic signed [SAMPLE_BITS-1:0]        hist_mem [MEM_DEPTH];

   // combinational
   logic                                 req_take;
   logic                                 ch_ok;
   logic [pfd_pkg::FACTOR_BITS-1:0]      factor_eff;
   logic                                 emit_in;
   logic                                 filt_in;
   logic [HIST_IDX_BITS-1:0]             rp_in;
   logic [MEM_AW-1:0]                    rd_addr;
   logic                                 mem_we;
   logic [MEM_AW-1:0]                    mem_wa;
   logic signed [SAMPLE_BITS-1:0]        operand;
   logic signed [ACC_BITS-1:0]           acc_rnd;
   logic signed [SAMPLE_BITS-1:0]        filt_y;
   logic                                 commit_go;
   logic [pfd_pkg::PHASE_BITS:0]         phase_inc;
   logic [pfd_pkg::PHASE_BITS-1:0]       phase_in;
   logic [HIST_IDX_BITS-1:0]             wp_in;
   logic [TAP_BITS-1:0]                  fill_in;
   logic                                 csr_wr;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == pfd_pkg::REG_DECIMATION_FACTOR);
   assign csr_prdata = (csr_paddr[2] == pfd_pkg::REG_DECIMATION_FACTOR) ?
                       pfd_pkg::CSR_DATA_BITS'(factor_ff) : '0;

   // zero acts as 1, anything above 16 as 16
   always_comb begin
      if (factor_ff == '0) begin
         factor_eff = pfd_pkg::FACTOR_BITS'(1);
      end else if (factor_ff > pfd_pkg::FACTOR_BITS'(pfd_pkg::FACTOR_MAX)) begin
         factor_eff = pfd_pkg::FACTOR_BITS'(pfd_pkg::FACTOR_MAX);
      end else begin
         factor_eff = factor_ff;
      end
   end

   // ---------------------------------------------------------- handshake
   assign req_stall       = (state_ff != ST_IDLE);
   assign req_take        = req_valid && (state_ff == ST_IDLE);
   assign ch_ok           = (int'(req_in_channel) < CHANNELS);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_sample  = rsp_sample_ff;
   assign rsp_out_channel = rsp_channel_ff;

   // phase zero emits; factor 2 runs the filter on those beats
   assign emit_in = (phase_ff[req_in_channel] == '0);
   assign filt_in = emit_in && (factor_eff == pfd_pkg::FACTOR_BITS'(pfd_pkg::FACTOR_FILTER));

   // circular read pointer, oldest entry first
   assign rp_in   = (rp_ff == HIST_IDX_BITS'(HIST_LEN - 1)) ? '0 : rp_ff + 1'b1;
   assign rd_addr = base_ff + MEM_AW'(rp_ff);

   // commit: append sample, advance pointer, fill count and phase
   assign commit_go = !emit_ff || !rsp_valid_ff || !rsp_stall;
   assign mem_we    = (state_ff == ST_COMMIT) && commit_go;
   assign mem_wa    = base_ff + MEM_AW'(wp_ff[ch_ff]);
   assign wp_in     = (wp_ff[ch_ff] == HIST_IDX_BITS'(HIST_LEN - 1)) ? '0 :
                      wp_ff[ch_ff] + 1'b1;
   assign fill_in   = (fill_ff[ch_ff] == TAP_BITS'(HIST_LEN)) ? fill_ff[ch_ff] :
                      fill_ff[ch_ff] + 1'b1;
   assign phase_inc = {1'b0, phase_ff[ch_ff]} + 1'b1;
   assign phase_in  = (phase_inc >= factor_eff) ? '0 :
                      phase_inc[pfd_pkg::PHASE_BITS-1:0];

   // unwritten history slots count as zero; the last tap uses the new sample
   always_comb begin
      if (s1_use_x_ff) begin
         operand = x_ff;
      end else if (s1_live_ff) begin
         operand = mem_rd_ff;
      end else begin
         operand = '0;
      end
   end

   // round half up, drop Q1.17 fraction, saturate
   always_comb begin
      acc_rnd = (acc_ff + ACC_BITS'(ROUND_HALF)) >>> pfd_pkg::COEF_FRAC;
      if ((&acc_rnd[ACC_BITS-1:SAMPLE_BITS-1]) || !(|acc_rnd[ACC_BITS-1:SAMPLE_BITS-1])) begin
         filt_y = acc_rnd[SAMPLE_BITS-1:0];
      end else if (acc_rnd[ACC_BITS-1]) begin
         filt_y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         filt_y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

   // ------------------------------------------------------- history RAM
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_wa] <= x_ff;
      end
      mem_rd_ff <= hist_mem[rd_addr];
   end

   // ------------------------------------------------- MAC pipeline data
   always_ff @(posedge clock) begin
      s1_use_x_ff <= (tap_ff == TAP_BITS'(TAPS - 1));
      s1_live_ff  <= (tap_ff >= start_ff);
      coef1_ff    <= COEF_ROM[ROM_IDX_BITS'(tap_ff)];
      prod_ff     <= coef1_ff * operand;
   end

   // ----------------------------------------------- sequencer and state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         factor_ff    <= pfd_pkg::FACTOR_BITS'(pfd_pkg::FACTOR_RESET);
         s1_act_ff    <= 1'b0;
         s2_act_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            phase_ff[c] <= '0;
            wp_ff[c]    <= '0;
            fill_ff[c]  <= '0;
         end
      end else begin
         if (csr_wr) begin
            factor_ff <= csr_pwdata[pfd_pkg::FACTOR_BITS-1:0];
         end

         s1_act_ff <= (state_ff == ST_RUN);
         s2_act_ff <= s1_act_ff;

         // a new result may replace one taken at the same edge
         if ((state_ff == ST_COMMIT) && commit_go && emit_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               // out-of-range channel: beat is taken and dropped
               if (req_take && ch_ok) begin
                  x_ff     <= req_in_sample;
                  ch_ff    <= req_in_channel;
                  emit_ff  <= emit_in;
                  filt_ff  <= filt_in;
                  base_ff  <= MEM_AW'(int'(req_in_channel) * HIST_LEN);
                  rp_ff    <= wp_ff[req_in_channel];
                  start_ff <= TAP_BITS'(HIST_LEN) - fill_ff[req_in_channel];
                  tap_ff   <= '0;
                  acc_ff   <= '0;
                  state_ff <= filt_in ? ST_RUN : ST_COMMIT;
               end
            end
            ST_RUN: begin
               tap_ff <= tap_ff + 1'b1;
               rp_ff  <= rp_in;
               if (tap_ff == TAP_BITS'(TAPS - 1)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!s1_act_ff && !s2_act_ff) begin
                  state_ff <= ST_COMMIT;
               end
            end
            ST_COMMIT: begin
               if (commit_go) begin
                  wp_ff[ch_ff]    <= wp_in;
                  fill_ff[ch_ff]  <= fill_in;
                  phase_ff[ch_ff] <= phase_in;
                  if (emit_ff) begin
                     rsp_sample_ff  <= filt_ff ? filt_y : x_ff;
                     rsp_channel_ff <= ch_ff;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         if (s2_act_ff) begin
            acc_ff <= acc_ff + ACC_BITS'(prod_ff);
         end
      end
   end

endmodule
`default_nettype wire

// File: bench/pfd_checker.sv
// ----------------------------------------------------------------------------
// pfd_checker
// Watches the sample, result and register ports of the PCM FIR decimator,
// keeps its own per-channel history, phase and coefficient table, works out
// the result of each accepted sample beat and compares it with the next
// result beat.
// ----------------------------------------------------------------------------
module pfd_checker #(
   parameter int TAPS        = 255,
   parameter int CHANNELS    = 2,
   parameter int SAMPLE_BITS = 24,
   localparam int CH_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   input  wire logic                                 req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0]        req_in_sample,
   input  wire logic [CH_BITS-1:0]                   req_in_channel,
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   input  wire logic signed [SAMPLE_BITS-1:0]        rsp_out_sample,
   input  wire logic [CH_BITS-1:0]                   rsp_out_channel,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [pfd_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  wire logic [pfd_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   input  wire logic                                 csr_pready,
   output int                                        failures,
   output int                                        outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [pfd_pkg::CSR_ADDR_BITS-1:0] ADDR_FACTOR =
      {pfd_pkg::REG_DECIMATION_FACTOR, 2'b00};
   localparam int     REPORT_LIMIT = 10;

   localparam longint ONE_Q30  = 64'sd1073741824;
   localparam longint PI_Q30   = 64'sd3373259426;
   localparam longint CUTOFF   = 64'sd78000;
   localparam longint RATE     = 64'sd352800;
   localparam longint BH_A0    = 64'sd35875;
   localparam longint BH_A1    = 64'sd48829;
   localparam longint BH_A2    = 64'sd14128;
   localparam longint BH_A3    = 64'sd1168;
   localparam longint BH_SCALE = 64'sd100000;
   localparam longint COEF_HI  = (64'sd1 <<< (pfd_pkg::COEF_BITS - 1)) - 1;
   localparam longint COEF_LO  = -(64'sd1 <<< (pfd_pkg::COEF_BITS - 1));
   localparam longint PCM_MAX  = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint PCM_MIN  = -(64'sd1 <<< (SAMPLE_BITS - 1));

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [CH_BITS-1:0]            channel;
   } pcm_beat_type;

   longint                             coef_q17 [TAPS];
   logic signed [SAMPLE_BITS-1:0]      history  [CHANNELS][TAPS-1];
   logic [pfd_pkg::PHASE_BITS-1:0]     phase    [CHANNELS];
   logic [pfd_pkg::FACTOR_BITS-1:0]    factor;
   pcm_beat_type                       due_q [$];

   // half-away-from-zero division
   function automatic longint round_div(input longint n, input longint d);
      if (d <= 0) return 0;
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
   endfunction

   function automatic longint q30_mul(input longint a, input longint b);
      return (a * b + (ONE_Q30 >>> 1)) >>> 30;
   endfunction

   // sin(pi * p / q) in Q30, Taylor series to x^15
   function automatic longint sin_pi_q30(input longint p, input longint q);
      longint r;
      longint a;
      longint a2;
      longint term;
      longint acc;
      bit     neg;
      r   = p % (2 * q);
      neg = 1'b0;
      if (r < 0) r = r + 2 * q;
      if (r >= q) begin
         r   = r - q;
         neg = 1'b1;
      end
      if (2 * r > q) r = q - r;
      a    = (PI_Q30 * r + q / 2) / q;
      a2   = q30_mul(a, a);
      term = a;
      acc  = a;
      for (int n = 1; n <= 7; n++) begin
         term = q30_mul(term, a2) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) acc = acc - term;
         else            acc = acc + term;
      end
      return neg ? -acc : acc;
   endfunction

   // Blackman-Harris windowed sinc, normalized to unity DC gain
   function automatic void build_coefs();
      longint h [TAPS];
      longint den;
      longint total;
      longint c1;
      longint c2;
      longint c3;
      longint w;
      longint x2;
      longint mag;
      longint sinc;
      longint s;
      longint theta;
      longint c;
      den   = TAPS - 1;
      total = 0;
      for (int i = 0; i < TAPS; i++) begin
         c1 = sin_pi_q30(4 * longint'(i) + den, 2 * den);
         c2 = sin_pi_q30(8 * longint'(i) + den, 2 * den);
         c3 = sin_pi_q30(12 * longint'(i) + den, 2 * den);
         w  = round_div(BH_A0 * ONE_Q30 - BH_A1 * c1 + BH_A2 * c2 - BH_A3 * c3, BH_SCALE);
         x2  = 2 * longint'(i) - den;
         mag = (x2 < 0) ? -x2 : x2;
         if (mag == 0) begin
            sinc = ONE_Q30;
         end else begin
            s     = sin_pi_q30(CUTOFF * mag, RATE);
            theta = round_div(PI_Q30 * CUTOFF * mag, RATE);
            sinc  = round_div(s * ONE_Q30, theta);
         end
         h[i]  = round_div(sinc * w, ONE_Q30);
         total = total + h[i];
      end
      if (total <= 0) total = 1;
      for (int i = 0; i < TAPS; i++) begin
         c = round_div(h[i] * (64'sd1 <<< pfd_pkg::COEF_FRAC), total);
         if (c > COEF_HI) c = COEF_HI;
         if (c < COEF_LO) c = COEF_LO;
         coef_q17[i] = c;
      end
   endfunction

   // advances one channel by one sample; returns 1 when a result is due
   function automatic bit decimate(input logic signed [SAMPLE_BITS-1:0] x,
                                   input logic [CH_BITS-1:0] ch,
                                   output pcm_beat_type y);
      int     f;
      int     p;
      bit     emit;
      longint acc;
      longint v;
      f = int'(factor);
      if (f == 0) f = 1;
      if (f > pfd_pkg::FACTOR_MAX) f = pfd_pkg::FACTOR_MAX;
      emit = (phase[ch] == '0);
      v    = longint'(x);
      if (emit && f == pfd_pkg::FACTOR_FILTER) begin
         acc = coef_q17[TAPS-1] * longint'(x);
         for (int i = 0; i < TAPS - 1; i++) acc = acc + coef_q17[i] * longint'(history[ch][i]);
         v = (acc + (64'sd1 <<< (pfd_pkg::COEF_FRAC - 1))) >>> pfd_pkg::COEF_FRAC;
         if (v > PCM_MAX) v = PCM_MAX;
         if (v < PCM_MIN) v = PCM_MIN;
      end
      // every sample enters the history, whatever the factor
      for (int i = 0; i < TAPS - 2; i++) history[ch][i] = history[ch][i+1];
      history[ch][TAPS-2] = x;
      p = int'(phase[ch]) + 1;
      if (p >= f) p = 0;
      phase[ch] = p[pfd_pkg::PHASE_BITS-1:0];
      y.sample  = v[SAMPLE_BITS-1:0];
      y.channel = ch;
      return emit;
   endfunction

   initial begin
      failures    = 0;
      outstanding = 0;
      build_coefs();
   end

   always @(posedge clock) begin : watch
      pcm_beat_type want;
      pcm_beat_type got;
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            phase[c] = '0;
            for (int i = 0; i < TAPS - 1; i++) history[c][i] = '0;
         end
         factor = pfd_pkg::FACTOR_BITS'(pfd_pkg::FACTOR_RESET);
         due_q.delete();
      end else begin
         // result side first: an expectation is never due in its own cycle
         if (rsp_valid && !rsp_stall) begin
            got.sample  = rsp_out_sample;
            got.channel = rsp_out_channel;
            if (due_q.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("%t: result beat with none due: sample %0d channel %0d",
                           $realtime, $signed(got.sample), got.channel);
            end else begin
               want = due_q.pop_front();
               if (got.sample !== want.sample || got.channel !== want.channel) begin
                  failures++;
                  if (failures <= REPORT_LIMIT)
                     $display("%t: expected sample %0d ch %0d, got sample %0d ch %0d",
                              $realtime, $signed(want.sample), want.channel,
                              $signed(got.sample), got.channel);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (decimate(req_in_sample, req_in_channel, want)) due_q.push_back(want);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == ADDR_FACTOR)
            factor = csr_pwdata[pfd_pkg::FACTOR_BITS-1:0];
      end
      outstanding = due_q.size();
   end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the PCM FIR decimator bench. Drives sample beats and register
// writes into the core, stalls the result side at random, and leaves the
// prediction and comparison to pfd_checker. A directed burst of extreme
// samples runs at the filtering factor, then random phases sweep the
// factor register through pass-through, filtered halving, keep-every-n-th,
// zero and out-of-range values.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TAPS        = 255;
   localparam int CHANNELS    = 2;
   localparam int SAMPLE_BITS = 24;

   // a filtered beat holds the core through its tap walk, drain and commit; leave margin on top
   localparam int DRAIN_CYCLES = TAPS + 40;
   localparam int CYCLE_LIMIT  = 2_000_000;

   localparam logic [pfd_pkg::CSR_ADDR_BITS-1:0] ADDR_FACTOR =
      {pfd_pkg::REG_DECIMATION_FACTOR, 2'b00};

   // phase table; FACTOR_PICK means a random register value 0..31
   localparam int FACTOR_PICK = -1;
   localparam int PHASES      = 12;
   localparam int PHASE_FACTOR [PHASES] = '{1, 0, 16, 17, 31, 3, 2, 7, 2,
                                            FACTOR_PICK, FACTOR_PICK, FACTOR_PICK};
   localparam int PHASE_BEATS  [PHASES] = '{100, 60, 150, 60, 60, 100, 350, 80, 190,
                                            25, 25, 25};
   // phases marked 1 run with no idling on either side
   localparam bit PHASE_CALM   [PHASES] = '{0, 0, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0};

   // full-scale corners, sign edges and alternating bit patterns
   localparam int EDGE_BEATS = 20;
   localparam logic [SAMPLE_BITS-1:0] EDGE_SAMPLE [EDGE_BEATS] = '{
      24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h000001,
      24'h555555, 24'hAAAAAA, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
      24'h800000, 24'h800001, 24'h7FFFFE, 24'h000000, 24'hFFFFFF,
      24'h400000, 24'hC00000, 24'h123456, 24'hEDCBA9, 24'h7FFFFF};
   localparam bit EDGE_CHANNEL [EDGE_BEATS] = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 0,
                                                1, 0, 1, 1, 0, 0, 1, 1, 0, 1};

   localparam logic signed [SAMPLE_BITS-1:0] PCM_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] PCM_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // shapes of the random sample runs
   typedef enum int {MIX_UNIFORM, MIX_EXTREME, MIX_SQUARE, MIX_QUIET} stim_mix_type;

   logic                                clock          = 1'b0;
   logic                                reset          = 1'b1;
   logic                                req_valid      = 1'b0;
   logic                                req_stall;
   logic signed [SAMPLE_BITS-1:0]       req_in_sample  = '0;
   logic                                req_in_channel = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall      = 1'b0;
   logic signed [SAMPLE_BITS-1:0]       rsp_out_sample;
   logic                                rsp_out_channel;
   logic                                csr_psel       = 1'b0;
   logic                                csr_penable    = 1'b0;
   logic                                csr_pwrite     = 1'b0;
   logic [pfd_pkg::CSR_ADDR_BITS-1:0]   csr_paddr      = '0;
   logic [pfd_pkg::CSR_DATA_BITS-1:0]   csr_pwdata     = '0;
   logic [pfd_pkg::CSR_DATA_BITS-1:0]   csr_prdata;
   logic                                csr_pready;

   int failures;
   int outstanding;
   int cycle_count = 0;
   bit calm        = 1'b0;   // no idling on either side while set
   int stall_run   = 0;      // cycles left in a long result stall

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pcm_fir_decimator_core #(
      .TAPS        (TAPS),
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_sample   (req_in_sample),
      .req_in_channel  (req_in_channel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_sample  (rsp_out_sample),
      .rsp_out_channel (rsp_out_channel),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   pfd_checker #(
      .TAPS        (TAPS),
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_sample   (req_in_sample),
      .req_in_channel  (req_in_channel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_sample  (rsp_out_sample),
      .rsp_out_channel (rsp_out_channel),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .failures        (failures),
      .outstanding     (outstanding)
   );

   // Result-side back-pressure: ~15% random stall, plus rare long stalls so
   // that a second result has to wait behind a held one.
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run <= stall_run - 1;
      end else if ($urandom_range(0, 199) == 0) begin
         rsp_stall <= 1'b1;
         stall_run <= $urandom_range(10, 60);
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 15);
      end
   end

   // watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   // Register write: setup cycle, then access cycle held until pready.
   // Called and returns in the time step of a rising edge.
   task automatic write_factor(input int value);
      logic [pfd_pkg::CSR_DATA_BITS-1:0] data;
      data = $urandom;
      // upper bits are don't-care for the 5-bit register; keep them quiet half the time
      if ($urandom_range(0, 1) == 0) data = '0;
      data[pfd_pkg::FACTOR_BITS-1:0] = value[pfd_pkg::FACTOR_BITS-1:0];
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_FACTOR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (!csr_pready);
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // One sample beat. Entered at a rising edge; returns at the edge where
   // the beat was taken, with req_valid still high. The optional idle gap
   // lowers valid in this step and raises it again after the gap, so valid
   // never sees two assignments in one step.
   task automatic send_beat(input logic signed [SAMPLE_BITS-1:0] sample, input logic ch);
      int gap;
      gap = (!calm && $urandom_range(0, 99) < 15) ? $urandom_range(1, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_in_sample  <= sample;
      req_in_channel <= ch;
      // stall is settled by the falling edge and holds through the next rise
      do @(negedge clock); while (req_stall);
      @(posedge clock);
   endtask

   // Lower valid after the last beat and wait until every due result is out,
   // then give the core time to finish a beat that yields none.
   task automatic quiesce();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random beats in runs of one shape: uniform noise, full-scale corners,
   // full-scale square waves (step overshoot drives the filter into
   // saturation) and small values around zero (rounding of negatives).
   task automatic play_random(input int count);
      stim_mix_type                  mix;
      int                            run_left;
      int                            half_period;
      int                            tick;
      logic signed [SAMPLE_BITS-1:0] s;
      run_left    = 0;
      mix         = MIX_UNIFORM;
      half_period = 1;
      tick        = 0;
      for (int k = 0; k < count; k++) begin
         if (run_left == 0) begin
            mix         = stim_mix_type'($urandom_range(0, 3));
            run_left    = $urandom_range(16, 160);
            half_period = $urandom_range(8, 120);
            tick        = 0;
         end
         run_left--;
         case (mix)
            MIX_UNIFORM: begin
               s = SAMPLE_BITS'($urandom);
            end
            MIX_EXTREME: begin
               case ($urandom_range(0, 4))
                  0:       s = PCM_MAX;
                  1:       s = PCM_MIN;
                  2:       s = '0;
                  3:       s = '1;
                  default: s = PCM_MIN + 1;
               endcase
            end
            MIX_SQUARE: begin
               s    = ((tick / half_period) % 2 == 0) ? PCM_MAX : PCM_MIN;
               tick = tick + 1;
            end
            default: begin
               s = SAMPLE_BITS'($urandom_range(0, 511)) - SAMPLE_BITS'(256);
            end
         endcase
         send_beat(s, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      int f;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed extremes at the filtering factor (also its reset value)
      write_factor(pfd_pkg::FACTOR_FILTER);
      for (int k = 0; k < EDGE_BEATS; k++) send_beat(EDGE_SAMPLE[k], EDGE_CHANNEL[k]);
      quiesce();

      // Random phases; each register change happens with the core idle.
      // Phases end with phases mid-count, so the next factor starts with a
      // phase that may lie beyond it.
      for (int ph = 0; ph < PHASES; ph++) begin
         f = (PHASE_FACTOR[ph] == FACTOR_PICK) ? $urandom_range(0, 31) : PHASE_FACTOR[ph];
         write_factor(f);
         calm <= PHASE_CALM[ph];
         play_random(PHASE_BEATS[ph]);
         quiesce();
      end

      if (failures == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
